@@ sv/sdaf_pkg.sv @@
// Shared constants, types and character codes for the signed decimal ASCII formatter.
`default_nettype none

package sdaf_pkg;

    localparam int DIGITS    = 5;
    localparam int VALUE_W   = 18;
    localparam int MAG_LIMIT = 10 ** DIGITS - 1;
    localparam int MAG_W     = $clog2(MAG_LIMIT + 1);
    localparam int SLOTS     = 2 * DIGITS;
    localparam int SLOT_W    = $clog2(SLOTS);

    // Reciprocal of ten scaled by 2^20; exact quotient for every magnitude up to MAG_LIMIT.
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(104858);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       show_sign;
        logic       neg;
        logic [2:0] places;
        logic [2:0] width;
    } fmt_t;

    // Digits are shifted in from the top, so after all division stages the
    // units digit sits at index 0 and the top digit is what is left of mag.
    typedef struct packed {
        fmt_t                       fmt;
        logic [MAG_W-1:0]           mag;
        logic [DIGITS-2:0][3:0]     digits;
    } work_t;

    typedef struct packed {
        logic [SLOTS-1:0]           emit;
        logic [SLOTS-1:0][7:0]      chars;
    } slots_t;

endpackage

`default_nettype wire

@@ sv/signed_decimal_ascii_formatter_core.sv @@
// Top level of the signed decimal ASCII formatter: pipeline and character stream.
// Throughput: one character per cycle while m_tready is high, set by the single character
// output register; a number has from 1 up to DIGITS + 2 characters, and the serializer
// takes the next number while it sends the last character of the one before.
// Reset: rst_n clears all valid bits at once; no number is in flight after reset.
`default_nettype none

module signed_decimal_ascii_formatter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[17:0], show_sign[18], decimal_places[21:19],
                                        // field_width[24:22], zero fill[31:25]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_char[7:0]
    output logic             m_tlast
);
    import sdaf_pkg::*;

    // Pipeline: magnitude stage, DIGITS - 1 division stages that each take off
    // one decimal digit, a layout stage that fixes every character slot, and
    // the serializer that sends the emitted slots one beat at a time. Every
    // stage holds its data while the next one stalls, so no beat is lost.
    work_t            pipe_data  [DIGITS];
    logic [DIGITS-1:0] pipe_valid;
    logic [DIGITS-1:0] pipe_ready;
    slots_t           slot_data;
    logic             slot_valid;
    logic             slot_ready;

    sdaf_abs u_abs (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .value          (s_tdata[VALUE_W-1:0]),
        .show_sign      (s_tdata[18]),
        .decimal_places (s_tdata[21:19]),
        .field_width    (s_tdata[24:22]),
        .out_valid      (pipe_valid[0]),
        .out_ready      (pipe_ready[0]),
        .out_data       (pipe_data[0])
    );

    for (genvar k = 0; k < DIGITS - 1; k++)
    begin : g_div
        sdaf_div10 u_div10 (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[k]),
            .in_ready  (pipe_ready[k]),
            .in_data   (pipe_data[k]),
            .out_valid (pipe_valid[k+1]),
            .out_ready (pipe_ready[k+1]),
            .out_data  (pipe_data[k+1])
        );
    end

    // After the last division the top digit is what is left of the magnitude.
    sdaf_slots u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid[DIGITS-1]),
        .in_ready  (pipe_ready[DIGITS-1]),
        .in_data   (pipe_data[DIGITS-1]),
        .out_valid (slot_valid),
        .out_ready (slot_ready),
        .out_data  (slot_data)
    );

    sdaf_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slot_valid),
        .in_ready  (slot_ready),
        .in_data   (slot_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .last_char (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/sdaf_abs.sv @@
// First pipeline stage: magnitude, sign handling and clamping of the input value.
`default_nettype none

module sdaf_abs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sdaf_pkg::VALUE_W-1:0] value,
    input  wire logic                        show_sign,
    input  wire logic [2:0]                  decimal_places,
    input  wire logic [2:0]                  field_width,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output sdaf_pkg::work_t                  out_data
);
    import sdaf_pkg::*;

    logic             valid_reg;
    work_t            data_reg;
    work_t            data_next;
    logic             neg;
    logic [VALUE_W-1:0] mag_full;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        neg      = value[VALUE_W-1];
        mag_full = neg ? (~value + VALUE_W'(1)) : value;
        data_next                  = '0;
        data_next.fmt.show_sign    = show_sign;
        data_next.fmt.neg          = neg;
        data_next.fmt.places       = decimal_places;
        data_next.fmt.width        = field_width;
        if (neg && !show_sign)
        begin
            data_next.mag = '0;
        end
        else if (mag_full > VALUE_W'(MAG_LIMIT))
        begin
            data_next.mag = MAG_W'(MAG_LIMIT);
        end
        else
        begin
            data_next.mag = mag_full[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sdaf_div10.sv @@
// Division stage: peels off the lowest decimal digit with a reciprocal multiply.
`default_nettype none

module sdaf_div10 (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  sdaf_pkg::work_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output sdaf_pkg::work_t out_data
);
    import sdaf_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;

    logic             valid_reg;
    work_t            data_reg;
    work_t            data_next;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0] quot;
    logic [MAG_W-1:0] rem_wide;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        prod     = PROD_W'(in_data.mag) * PROD_W'(RECIP);
        quot     = MAG_W'(prod >> RECIP_SHIFT);
        rem_wide = in_data.mag - ((quot << 3) + (quot << 1));
        data_next        = in_data;
        data_next.mag    = quot;
        data_next.digits = {rem_wide[3:0], in_data.digits[DIGITS-2:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sdaf_slots.sv @@
// Layout stage: decides for every character slot whether it is emitted and what it holds.
`default_nettype none

module sdaf_slots (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  sdaf_pkg::work_t in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output sdaf_pkg::slots_t out_data
);
    import sdaf_pkg::*;

    logic                   valid_reg;
    slots_t                 data_reg;
    slots_t                 data_next;
    logic [DIGITS-1:0][3:0] dig;
    logic [DIGITS-1:0]      zero_above;
    logic [SLOT_W-1:0]      slot;
    logic [SLOT_W-1:0]      point_slot;
    logic                   suppress;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = '0;
        slot       = '0;
        point_slot = '0;
        dig[DIGITS-1] = in_data.mag[3:0];
        for (int p = 0; p < DIGITS - 1; p++)
        begin
            dig[p] = in_data.digits[p];
        end
        // zero_above[p]: digits at power p and above are all zero.
        zero_above[DIGITS-1] = (dig[DIGITS-1] == 4'd0);
        for (int p = DIGITS - 2; p >= 0; p--)
        begin
            zero_above[p] = zero_above[p+1] && (dig[p] == 4'd0);
        end

        data_next.emit[0]  = in_data.fmt.show_sign;
        data_next.chars[0] = in_data.fmt.neg ? CH_MINUS : CH_PLUS;

        for (int p = DIGITS - 1; p >= 1; p--)
        begin
            slot       = SLOT_W'(1 + 2 * (DIGITS - 1 - p));
            point_slot = slot + SLOT_W'(1);
            suppress   = zero_above[p] && (int'(in_data.fmt.places) < p);
            if (suppress)
            begin
                data_next.emit[slot]  = (int'(in_data.fmt.width) >= p + 1);
                data_next.chars[slot] = CH_SPACE;
            end
            else
            begin
                data_next.emit[slot]  = 1'b1;
                data_next.chars[slot] = CH_ZERO + {4'd0, dig[p]};
            end
            data_next.emit[point_slot]  = (int'(in_data.fmt.places) == p);
            data_next.chars[point_slot] = CH_POINT;
        end

        data_next.emit[SLOTS-1]  = 1'b1;
        data_next.chars[SLOTS-1] = CH_ZERO + {4'd0, dig[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sdaf_ser.sv @@
// Serializer: walks the emitted slots of one number and sends one character per beat.
`default_nettype none

module sdaf_ser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  sdaf_pkg::slots_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             last_char
);
    import sdaf_pkg::*;

    logic [SLOTS-1:0]      mask_reg;
    logic [SLOTS-1:0]      mask_next;
    logic [SLOTS-1:0][7:0] chars_reg;
    logic                  out_valid_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;
    logic                  adv;
    logic [SLOT_W-1:0]     first;
    logic [SLOTS-1:0]      rest;

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    // The output register can take a new character when empty or being drained.
    assign adv = (!out_valid_reg || out_ready) && (mask_reg != '0);

    always_comb
    begin
        first = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                first = SLOT_W'(i);
            end
        end
        rest        = mask_reg;
        rest[first] = 1'b0;
        in_ready    = (mask_reg == '0) || (adv && (rest == '0));
        if (in_ready && in_valid)
        begin
            mask_next = in_data.emit;
        end
        else if (adv)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            chars_reg <= in_data.chars;
        end
        if (adv)
        begin
            char_reg <= chars_reg[first];
            last_reg <= (rest == '0);
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the signed decimal ASCII formatter core.
`timescale 1ns / 1ps

module tb_top;

    import sdaf_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_IDLE       = 18;
    localparam int RANDOM_NUMBERS = 145;
    localparam int HOLD_AT_CHAR   = 400;   // character count at which the sink stops
    localparam int HOLD_CYCLES    = 200;   // length of that stop
    localparam int DRAIN_CYCLES   = 30;    // more than the pipeline depth
    localparam int WATCHDOG_LIMIT = 2000;

    // One character on the output stream.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_beat_t;

    // Holds the characters still owed by the block and checks each one that arrives.
    class ascii_scoreboard;
        ascii_beat_t expected_chars[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return expected_chars.size();
        endfunction

        function void push_char(logic [7:0] ch, logic last);
            ascii_beat_t beat;
            beat.ch   = ch;
            beat.last = last;
            expected_chars.push_back(beat);
        endfunction

        // Works out the character run for one accepted number.
        function void note_number(logic [VALUE_W-1:0] value, logic show_sign,
                                  logic [2:0] places, logic [2:0] width);
            int  signed_value;
            int  mag;
            int  digit[DIGITS];
            bit  neg;
            bit  leading;
            signed_value = int'($signed(value));
            neg          = value[VALUE_W-1];
            mag          = neg ? -signed_value : signed_value;
            if (show_sign)
            begin
                push_char(neg ? CH_MINUS : CH_PLUS, 1'b0);
            end
            else if (neg)
            begin
                mag = 0;
            end
            if (mag > MAG_LIMIT)
            begin
                mag = MAG_LIMIT;
            end
            for (int p = 0; p < DIGITS; p++)
            begin
                digit[p] = mag % 10;
                mag      = mag / 10;
            end
            // Leading zeros above the point are blanked; inside the width they
            // become spaces, outside it they vanish.
            leading = 1'b1;
            for (int p = DIGITS - 1; p >= 1; p--)
            begin
                if (digit[p] == 0 && leading && int'(places) < p)
                begin
                    if (int'(width) >= p + 1)
                    begin
                        push_char(CH_SPACE, 1'b0);
                    end
                end
                else
                begin
                    push_char(8'(CH_ZERO + digit[p]), 1'b0);
                    leading = 1'b0;
                end
                if (int'(places) == p)
                begin
                    push_char(CH_POINT, 1'b0);
                end
            end
            push_char(8'(CH_ZERO + digit[0]), 1'b1);
        endfunction

        task check_char(logic [7:0] ch, logic last);
            ascii_beat_t want;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected char 0x%h last %b", ch, last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (ch !== want.ch)
                begin
                    report($sformatf("char 0x%h, expected 0x%h", ch, want.ch));
                end
                if (last !== want.last)
                begin
                    report($sformatf("last %b, expected %b on char 0x%h", last, want.last,
                                     want.ch));
                end
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    ascii_scoreboard char_board;
    int              numbers_sent;
    int              chars_seen;
    int              idle_cycles;

    signed_decimal_ascii_formatter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value[17:0], show_sign[18], decimal_places[21:19],
                                // field_width[24:22], zero fill[31:25]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_char[7:0]
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Gaps come in stretches: two stretches of twenty numbers with gaps, one without.
    function automatic bit sender_pauses();
        return ((numbers_sent / 20) % 3) != 2;
    endfunction

    function automatic bit sink_pauses();
        return ((chars_seen / 60) % 3) != 2;
    endfunction

    // Offers one number after a random gap and waits until the block takes the beat.
    task automatic send_number(int value, bit show_sign, int places, int width);
        logic [31:0] word;
        int          gap;
        word = {7'd0, 3'(width), 3'(places), show_sign, VALUE_W'(value)};
        gap  = sender_pauses() ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        char_board.note_number(word[17:0], word[18], word[21:19], word[24:22]);
        numbers_sent++;
    endtask

    // Takes one character after a random stall and hands it to the scoreboard.
    task automatic take_char();
        int stall;
        stall = sink_pauses() ? $urandom_range(0, MAX_IDLE) : 0;
        if (stall > 0)
        begin
            @(negedge clk);
            m_tready <= 1'b0;
            repeat (stall - 1) @(negedge clk);
        end
        @(negedge clk);
        m_tready <= 1'b1;
        do @(posedge clk); while (!m_tvalid);
        char_board.check_char(m_tdata, m_tlast);
        chars_seen++;
    endtask

    task automatic sink_loop();
        bit held;
        held = 1'b0;
        forever
        begin
            // Once, the sink stops for a long stretch so that the pipeline fills
            // and the input side has to back off while numbers keep coming.
            if (!held && chars_seen >= HOLD_AT_CHAR)
            begin
                held = 1'b1;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            take_char();
        end
    endtask

    function automatic int draw_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            // Anything the 18-bit field can hold, clamped cases included.
            return int'($urandom_range(0, 262143)) - 131072;
        end
        else if (pick < 3)
        begin
            return int'($urandom_range(0, 198)) - 99;
        end
        return int'($urandom_range(0, 199998)) - 99999;
    endfunction

    // Watchdog: ends the run when neither side has moved a beat for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        char_board   = new();
        numbers_sent = 0;
        chars_seen   = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            sink_loop();
        join_none

        // Directed numbers: extremes, clamping, signs, every point position and width.
        send_number(99999, 1'b1, 0, 5);
        send_number(-99999, 1'b1, 0, 5);
        send_number(0, 1'b1, 0, 1);          // zero takes a plus sign
        send_number(0, 1'b0, 0, 5);
        send_number(-5, 1'b0, 0, 3);         // negative with no sign shows zero
        send_number(131071, 1'b1, 0, 5);     // largest field value, clamped
        send_number(-131072, 1'b1, 2, 5);    // most negative field value, clamped
        send_number(100000, 1'b0, 1, 4);
        send_number(12345, 1'b0, 0, 5);
        send_number(12345, 1'b1, 1, 5);
        send_number(-12345, 1'b1, 2, 5);
        send_number(12345, 1'b0, 3, 5);
        send_number(12345, 1'b0, 4, 5);
        send_number(7, 1'b0, 5, 3);          // point positions past the digits
        send_number(7, 1'b1, 6, 3);
        send_number(-7, 1'b1, 7, 3);
        send_number(42, 1'b0, 0, 0);         // width zero drops every blank
        send_number(42, 1'b0, 0, 1);
        send_number(42, 1'b0, 0, 2);
        send_number(42, 1'b1, 1, 3);
        send_number(42, 1'b0, 0, 6);         // widths past the digits act as full width
        send_number(42, 1'b0, 0, 7);
        send_number(5, 1'b0, 4, 1);
        send_number(-1, 1'b1, 2, 0);
        send_number(30001, 1'b1, 3, 4);

        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            int places;
            int width;
            places = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            width  = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            send_number(draw_value(), 1'($urandom_range(0, 1)), places, width);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (char_board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (char_board.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/sdaf_pkg.sv
sv/sdaf_abs.sv
sv/sdaf_div10.sv
sv/sdaf_slots.sv
sv/sdaf_ser.sv
sv/signed_decimal_ascii_formatter_core.sv
tb/tb_top.sv
